@@ src/rrts_pkg.sv @@
// ----------------------------------------------------------------------------
// rrts_pkg
// shared types and codes of the round-robin thread scheduler
// ----------------------------------------------------------------------------
package rrts_pkg;

  // event codes
  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_START  = 3'd1,
    OP_YIELD  = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_FINISH = 3'd4,
    OP_JOIN   = 3'd5,
    OP_TICK   = 3'd6,
    OP_NOP    = 3'd7
  } op_e;

  // answer codes
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_ID      = 3'd1,
    ST_JOINED      = 3'd2,
    ST_NO_SLOT     = 3'd3,
    ST_NOT_DONE    = 3'd4,
    ST_NO_RUN      = 3'd5,
    ST_WAIT_SLEEP  = 3'd6,
    ST_RSVD        = 3'd7
  } status_e;

  // per-slot thread state
  typedef enum logic [2:0] {
    SLOT_UNUSED   = 3'd0,
    SLOT_READY    = 3'd1,
    SLOT_RUNNING  = 3'd2,
    SLOT_SLEEPING = 3'd3,
    SLOT_FINISHED = 3'd4
  } slot_st_e;

  // scan flavor of the slot sweep
  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_WAKE  = 2'd1,
    MODE_TICK  = 2'd2
  } mode_e;

  typedef enum logic [9:0] {
    FSM_IDLE   = 10'b00_0000_0001,
    FSM_DECODE = 10'b00_0000_0010,
    FSM_CRD    = 10'b00_0000_0100,
    FSM_CWR    = 10'b00_0000_1000,
    FSM_CHK    = 10'b00_0001_0000,
    FSM_JCHK   = 10'b00_0010_0000,
    FSM_PASS   = 10'b00_0100_0000,
    FSM_DISP   = 10'b00_1000_0000,
    FSM_DISP2  = 10'b01_0000_0000,
    FSM_DONE   = 10'b10_0000_0000
  } fsm_e;

  // slot memory write enables
  typedef struct packed {
    logic we_st;
    logic we_ext;
  } slot_ctl_t;

  // free id stack commands
  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctl_t;

endpackage

@@ src/round_robin_thread_scheduler.sv @@
// ----------------------------------------------------------------------------
// round_robin_thread_scheduler
// hardware thread-slot scheduler with round-robin dispatch and timed sleep
// ----------------------------------------------------------------------------
// Each input beat is one scheduler event (create, start, yield, sleep, finish,
// join, tick) and gives exactly one result beat with a status, a thread id
// and a running flag. Slot state lives in a state memory and a joined/wake
// memory, both with a registered read; released ids live in a small
// stack memory. Events are handled one at a time by a sequencer. Create,
// join, tick without a pending dispatch and the simple cases pass from
// decode through at most a stack read, a slot write or a join check to the
// result. Yield, sleep, finish, start and a tick that completes a pending
// dispatch sweep all slots in use through the memory read port, one slot
// per cycle, a pace set by that single read port. No clearing
// pass is needed after reset: only slots below the high-water count of
// handed-out ids are ever read, and each is written when it is first created.
// A result waits in the output register until taken; the next event is
// accepted as soon as a result enters that register, and its own result is
// held in the sequencer until the register frees up.
// ----------------------------------------------------------------------------
module round_robin_thread_scheduler #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [15:0] sleep_seconds_i,
  input  logic [3:0] target_thread_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [2:0] status_o,
  output logic [3:0] result_thread_o,
  output logic       running_valid_o
);

  localparam int unsigned IdW  = (SLOT_COUNT > 2) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CntW = $clog2(SLOT_COUNT + 1);
  localparam int unsigned CmpW = (CntW > 4) ? CntW : 4;

  rrts_pkg::fsm_e    state_q, state_d;
  rrts_pkg::mode_e   mode_q, mode_d;
  rrts_pkg::status_e stat_q, stat_d;
  rrts_pkg::slot_st_e cur_post_q, cur_post_d;

  logic [2:0]      op_q;
  logic [15:0]     secs_q;
  logic [3:0]      tgt_q;
  logic [IdW-1:0]  tid_q, tid_d;
  logic [CntW-1:0] in_use_q, in_use_d;
  logic [IdW-1:0]  cur_q, cur_d;
  logic            cur_vld_q, cur_vld_d;
  logic            active_q, active_d;
  logic            pend_q, pend_d;
  logic [31:0]     now_q, now_d;

  // sweep bookkeeping
  logic [CntW-1:0] iss_q, iss_d;
  logic            rd_vld_q, rd_vld_d;
  logic [IdW-1:0]  rd_idx_q, rd_idx_d;
  logic            hi_fnd_q, hi_fnd_d, lo_fnd_q, lo_fnd_d;
  logic [IdW-1:0]  hi_q, hi_d, lo_q, lo_d;
  logic            any_slp_q, any_slp_d, woke_q, woke_d;

  // output register
  logic            out_vld_q;
  logic [2:0]      out_stat_q;
  logic [3:0]      out_thr_q;
  logic            out_run_q;
  logic            out_load;

  // memory ports
  rrts_pkg::slot_ctl_t slot_ctl;
  rrts_pkg::stk_ctl_t  stk_ctl;
  logic [IdW-1:0]  m_raddr, m_waddr;
  logic [2:0]      m_wst;
  logic            m_wjoined;
  logic [31:0]     m_wwake;
  logic [2:0]      m_rd_st;
  logic            m_rd_joined;
  logic [31:0]     m_rd_wake;
  logic [CntW-1:0] stk_top;
  logic [IdW-1:0]  stk_pop_id;
  logic [IdW-1:0]  tgt_idx;

  // per-entry sweep logic
  rrts_pkg::slot_st_e s_old, s_new;
  logic [31:0]     w_new;
  logic            is_cur, is_cand;

  rrts_slot_mem #(
    .SlotCount (SLOT_COUNT),
    .IdW       (IdW)
  ) u_slot_mem (
    .clk_i       (clk_i),
    .ctl_i       (slot_ctl),
    .raddr_i     (m_raddr),
    .waddr_i     (m_waddr),
    .wst_i       (m_wst),
    .wjoined_i   (m_wjoined),
    .wwake_i     (m_wwake),
    .rd_st_o     (m_rd_st),
    .rd_joined_o (m_rd_joined),
    .rd_wake_o   (m_rd_wake)
  );

  rrts_free_stack #(
    .SlotCount (SLOT_COUNT),
    .IdW       (IdW),
    .CntW      (CntW)
  ) u_free_stack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (stk_ctl),
    .push_id_i (tgt_idx),
    .top_o     (stk_top),
    .pop_id_o  (stk_pop_id)
  );

  assign tgt_idx    = IdW'(tgt_q);
  assign in_ready_o = (state_q == rrts_pkg::FSM_IDLE);
  assign out_load   = (state_q == rrts_pkg::FSM_DONE) && (!out_vld_q || out_ready_i);

  // new value of the slot that the sweep is looking at
  always_comb begin
    s_old = rrts_pkg::slot_st_e'(m_rd_st);
    s_new = s_old;
    w_new = m_rd_wake;
    is_cur = (rd_idx_q == cur_q);
    if (mode_q == rrts_pkg::MODE_WAKE) begin
      if (is_cur && (op_q == rrts_pkg::OP_SLEEP)) begin
        s_new = rrts_pkg::SLOT_SLEEPING;
        w_new = now_q + {16'd0, secs_q};
      end else if (is_cur && (op_q == rrts_pkg::OP_FINISH)) begin
        s_new = rrts_pkg::SLOT_FINISHED;
      end
      if ((s_new == rrts_pkg::SLOT_SLEEPING) && (w_new <= now_q)) begin
        s_new = rrts_pkg::SLOT_READY;
      end
    end else if (mode_q == rrts_pkg::MODE_TICK) begin
      // a tick wakes only the lowest due sleeper
      if (!woke_q && (s_old == rrts_pkg::SLOT_SLEEPING) && (m_rd_wake <= now_q)) begin
        s_new = rrts_pkg::SLOT_READY;
      end
    end
    is_cand = (s_new == rrts_pkg::SLOT_READY) ||
              ((s_new == rrts_pkg::SLOT_RUNNING) && !is_cur);
  end

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    stat_d     = stat_q;
    cur_post_d = cur_post_q;
    tid_d      = tid_q;
    in_use_d   = in_use_q;
    cur_d      = cur_q;
    cur_vld_d  = cur_vld_q;
    active_d   = active_q;
    pend_d     = pend_q;
    now_d      = now_q;
    iss_d      = iss_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    hi_fnd_d   = hi_fnd_q;
    lo_fnd_d   = lo_fnd_q;
    hi_d       = hi_q;
    lo_d       = lo_q;
    any_slp_d  = any_slp_q;
    woke_d     = woke_q;
    slot_ctl   = '0;
    stk_ctl    = '0;
    m_raddr    = cur_q;
    m_waddr    = rd_idx_q;
    m_wst      = s_new;
    m_wjoined  = m_rd_joined;
    m_wwake    = w_new;

    unique case (state_q)
      rrts_pkg::FSM_IDLE: begin
        if (in_valid_i) begin
          state_d = rrts_pkg::FSM_DECODE;
        end
      end

      rrts_pkg::FSM_DECODE: begin
        // fresh sweep state for whatever follows
        iss_d     = '0;
        hi_fnd_d  = 1'b0;
        lo_fnd_d  = 1'b0;
        any_slp_d = 1'b0;
        woke_d    = 1'b0;
        cur_post_d = rrts_pkg::SLOT_UNUSED;
        stat_d    = rrts_pkg::ST_OK;
        state_d   = rrts_pkg::FSM_DONE;
        case (op_q)
          rrts_pkg::OP_CREATE: begin
            if (stk_top != '0) begin
              stk_ctl.pop = 1'b1;
              state_d = rrts_pkg::FSM_CRD;
            end else if (in_use_q >= CntW'(SLOT_COUNT)) begin
              stat_d = rrts_pkg::ST_NO_SLOT;
            end else begin
              tid_d    = in_use_q[IdW-1:0];
              in_use_d = in_use_q + CntW'(1);
              state_d  = rrts_pkg::FSM_CWR;
            end
          end
          rrts_pkg::OP_START: begin
            if (!(active_q && cur_vld_q)) begin
              pend_d  = 1'b0;
              mode_d  = rrts_pkg::MODE_START;
              state_d = rrts_pkg::FSM_PASS;
            end
          end
          rrts_pkg::OP_YIELD: begin
            if (!active_q || !cur_vld_q) begin
              stat_d = rrts_pkg::ST_NO_RUN;
            end else begin
              mode_d  = rrts_pkg::MODE_WAKE;
              state_d = rrts_pkg::FSM_PASS;
            end
          end
          rrts_pkg::OP_SLEEP, rrts_pkg::OP_FINISH: begin
            if (!active_q || !cur_vld_q) begin
              stat_d = rrts_pkg::ST_NO_RUN;
            end else begin
              m_raddr = cur_q;
              state_d = rrts_pkg::FSM_CHK;
            end
          end
          rrts_pkg::OP_JOIN: begin
            if (CmpW'(tgt_q) >= CmpW'(in_use_q)) begin
              stat_d = rrts_pkg::ST_BAD_ID;
            end else begin
              m_raddr = tgt_idx;
              state_d = rrts_pkg::FSM_JCHK;
            end
          end
          rrts_pkg::OP_TICK: begin
            now_d = now_q + 32'd1;
            if (pend_q && active_q && cur_vld_q) begin
              mode_d  = rrts_pkg::MODE_TICK;
              state_d = rrts_pkg::FSM_PASS;
            end
          end
          default: begin
          end
        endcase
      end

      rrts_pkg::FSM_CRD: begin
        tid_d   = stk_pop_id;
        state_d = rrts_pkg::FSM_CWR;
      end

      rrts_pkg::FSM_CWR: begin
        slot_ctl.we_st  = 1'b1;
        slot_ctl.we_ext = 1'b1;
        m_waddr   = tid_q;
        m_wst     = rrts_pkg::SLOT_READY;
        m_wjoined = 1'b0;
        m_wwake   = '0;
        state_d   = rrts_pkg::FSM_DONE;
      end

      rrts_pkg::FSM_CHK: begin
        if (m_rd_st != rrts_pkg::SLOT_RUNNING) begin
          stat_d  = pend_q ? rrts_pkg::ST_WAIT_SLEEP : rrts_pkg::ST_NO_RUN;
          state_d = rrts_pkg::FSM_DONE;
        end else begin
          mode_d  = rrts_pkg::MODE_WAKE;
          state_d = rrts_pkg::FSM_PASS;
        end
      end

      rrts_pkg::FSM_JCHK: begin
        state_d = rrts_pkg::FSM_DONE;
        if (m_rd_joined) begin
          stat_d = rrts_pkg::ST_JOINED;
        end else if (m_rd_st != rrts_pkg::SLOT_FINISHED) begin
          stat_d = rrts_pkg::ST_NOT_DONE;
        end else begin
          slot_ctl.we_ext = 1'b1;
          m_waddr   = tgt_idx;
          m_wjoined = 1'b1;
          m_wwake   = m_rd_wake;
          stk_ctl.push = 1'b1;
        end
      end

      rrts_pkg::FSM_PASS: begin
        // issue one read per cycle, handle the entry whose read was issued the cycle before
        m_raddr = iss_q[IdW-1:0];
        if (iss_q < in_use_q) begin
          iss_d    = iss_q + CntW'(1);
          rd_vld_d = 1'b1;
          rd_idx_d = iss_q[IdW-1:0];
        end else if (!rd_vld_q) begin
          state_d = rrts_pkg::FSM_DISP;
        end
        if (rd_vld_q) begin
          if (mode_q == rrts_pkg::MODE_START) begin
            if ((s_old == rrts_pkg::SLOT_READY) && !lo_fnd_q) begin
              lo_fnd_d = 1'b1;
              lo_d     = rd_idx_q;
            end
          end else begin
            slot_ctl.we_st  = 1'b1;
            slot_ctl.we_ext = (mode_q == rrts_pkg::MODE_WAKE) && is_cur &&
                              (op_q == rrts_pkg::OP_SLEEP);
            if ((mode_q == rrts_pkg::MODE_TICK) && (s_new != s_old)) begin
              woke_d = 1'b1;
            end
            if (is_cand) begin
              if (rd_idx_q > cur_q) begin
                if (!hi_fnd_q) begin
                  hi_fnd_d = 1'b1;
                  hi_d     = rd_idx_q;
                end
              end else if (!lo_fnd_q) begin
                lo_fnd_d = 1'b1;
                lo_d     = rd_idx_q;
              end
            end
            if (s_new == rrts_pkg::SLOT_SLEEPING) begin
              any_slp_d = 1'b1;
            end
            if (is_cur) begin
              cur_post_d = s_new;
            end
          end
        end
      end

      rrts_pkg::FSM_DISP: begin
        state_d = rrts_pkg::FSM_DONE;
        if (mode_q == rrts_pkg::MODE_START) begin
          if (lo_fnd_q) begin
            slot_ctl.we_st = 1'b1;
            m_waddr   = lo_q;
            m_wst     = rrts_pkg::SLOT_RUNNING;
            cur_d     = lo_q;
            cur_vld_d = 1'b1;
            active_d  = 1'b1;
          end else begin
            cur_vld_d = 1'b0;
            active_d  = 1'b0;
            stat_d    = rrts_pkg::ST_NO_RUN;
          end
        end else if ((mode_q == rrts_pkg::MODE_TICK) && !woke_q) begin
          stat_d = rrts_pkg::ST_WAIT_SLEEP;
        end else if (hi_fnd_q || lo_fnd_q) begin
          // demote the old runner first, promote the pick next cycle
          if (cur_post_q == rrts_pkg::SLOT_RUNNING) begin
            slot_ctl.we_st = 1'b1;
            m_waddr = cur_q;
            m_wst   = rrts_pkg::SLOT_READY;
          end
          state_d = rrts_pkg::FSM_DISP2;
        end else if (any_slp_q) begin
          pend_d = 1'b1;
          stat_d = rrts_pkg::ST_WAIT_SLEEP;
        end else begin
          pend_d = 1'b0;
          if (cur_post_q != rrts_pkg::SLOT_RUNNING) begin
            stat_d = rrts_pkg::ST_NO_RUN;
          end
          if (cur_post_q == rrts_pkg::SLOT_FINISHED) begin
            cur_vld_d = 1'b0;
            active_d  = 1'b0;
          end
        end
      end

      rrts_pkg::FSM_DISP2: begin
        slot_ctl.we_st = 1'b1;
        m_waddr = hi_fnd_q ? hi_q : lo_q;
        m_wst   = rrts_pkg::SLOT_RUNNING;
        cur_d   = hi_fnd_q ? hi_q : lo_q;
        pend_d  = 1'b0;
        stat_d  = rrts_pkg::ST_OK;
        state_d = rrts_pkg::FSM_DONE;
      end

      rrts_pkg::FSM_DONE: begin
        if (out_load) begin
          state_d = rrts_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_d = rrts_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrts_pkg::FSM_IDLE;
      in_use_q  <= '0;
      cur_vld_q <= 1'b0;
      active_q  <= 1'b0;
      pend_q    <= 1'b0;
      now_q     <= '0;
      rd_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      in_use_q  <= in_use_d;
      cur_vld_q <= cur_vld_d;
      active_q  <= active_d;
      pend_q    <= pend_d;
      now_q     <= now_d;
      rd_vld_q  <= rd_vld_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload and sweep registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      op_q   <= op_i;
      secs_q <= sleep_seconds_i;
      tgt_q  <= target_thread_i;
    end
    mode_q     <= mode_d;
    stat_q     <= stat_d;
    cur_post_q <= cur_post_d;
    tid_q      <= tid_d;
    cur_q      <= cur_d;
    iss_q      <= iss_d;
    rd_idx_q   <= rd_idx_d;
    hi_fnd_q   <= hi_fnd_d;
    lo_fnd_q   <= lo_fnd_d;
    hi_q       <= hi_d;
    lo_q       <= lo_d;
    any_slp_q  <= any_slp_d;
    woke_q     <= woke_d;
    if (out_load) begin
      out_stat_q <= stat_q;
      out_run_q  <= cur_vld_q;
      if (op_q == rrts_pkg::OP_CREATE) begin
        out_thr_q <= (stat_q == rrts_pkg::ST_OK) ? 4'(tid_q) : 4'd0;
      end else begin
        out_thr_q <= cur_vld_q ? 4'(cur_q) : 4'd0;
      end
    end
  end

  assign out_valid_o     = out_vld_q;
  assign status_o        = out_stat_q;
  assign result_thread_o = out_thr_q;
  assign running_valid_o = out_run_q;

`ifndef SYNTHESIS
  // a pending dispatch only exists while the scheduler runs a slot
  a_pend_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (active_q && cur_vld_q))
    else $error("dispatch pending without a current slot");

  // released ids never outnumber handed-out ids
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_top <= in_use_q)
    else $error("free stack deeper than slots in use");

  // the current slot always lies below the high-water count
  a_cur_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (CntW'(cur_q) < in_use_q))
    else $error("current slot beyond slots in use");

  // an accepted event goes straight to decode
  a_accept_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == rrts_pkg::FSM_DECODE))
    else $error("accepted beat not decoded");
`endif

endmodule

@@ src/rrts_slot_mem.sv @@
// ----------------------------------------------------------------------------
// rrts_slot_mem
// slot state memory and slot joined/wake-time memory, registered read
// ----------------------------------------------------------------------------
module rrts_slot_mem #(
  parameter int unsigned SlotCount = 16,
  parameter int unsigned IdW       = 4
) (
  input  logic               clk_i,
  input  rrts_pkg::slot_ctl_t ctl_i,
  input  logic [IdW-1:0]     raddr_i,
  input  logic [IdW-1:0]     waddr_i,
  input  logic [2:0]         wst_i,
  input  logic               wjoined_i,
  input  logic [31:0]        wwake_i,
  output logic [2:0]         rd_st_o,
  output logic               rd_joined_o,
  output logic [31:0]        rd_wake_o
);

  logic [2:0]  st_mem  [SlotCount];
  logic [32:0] ext_mem [SlotCount];
  logic [32:0] ext_rd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_st) begin
      st_mem[waddr_i] <= wst_i;
    end
    rd_st_o <= st_mem[raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.we_ext) begin
      ext_mem[waddr_i] <= {wjoined_i, wwake_i};
    end
    ext_rd_q <= ext_mem[raddr_i];
  end

  assign rd_joined_o = ext_rd_q[32];
  assign rd_wake_o   = ext_rd_q[31:0];

endmodule

@@ src/rrts_free_stack.sv @@
// ----------------------------------------------------------------------------
// rrts_free_stack
// stack of released thread ids with its top pointer
// ----------------------------------------------------------------------------
module rrts_free_stack #(
  parameter int unsigned SlotCount = 16,
  parameter int unsigned IdW       = 4,
  parameter int unsigned CntW      = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rrts_pkg::stk_ctl_t ctl_i,
  input  logic [IdW-1:0]     push_id_i,
  output logic [CntW-1:0]    top_o,
  output logic [IdW-1:0]     pop_id_o
);

  logic [IdW-1:0]  stk_mem [SlotCount];
  logic [CntW-1:0] top_q, top_d;
  logic [CntW-1:0] top_m1;

  assign top_m1 = top_q - CntW'(1);

  always_comb begin
    top_d = top_q;
    if (ctl_i.push) begin
      top_d = top_q + CntW'(1);
    end else if (ctl_i.pop) begin
      top_d = top_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
    end else begin
      top_q <= top_d;
    end
  end

  // read of the entry under the top, registered
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      stk_mem[top_q[IdW-1:0]] <= push_id_i;
    end
    pop_id_o <= stk_mem[top_m1[IdW-1:0]];
  end

  assign top_o = top_q;

endmodule

@@ sim/rrts_checker.sv @@
// ----------------------------------------------------------------------------
// rrts_checker
// predicts each scheduler answer from the accepted events and compares them
// ----------------------------------------------------------------------------
module rrts_checker #(
  parameter int unsigned SLOT_COUNT = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  op_i,
  input  logic [15:0] sleep_seconds_i,
  input  logic [3:0]  target_thread_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [2:0]  status_i,
  input  logic [3:0]  result_thread_i,
  input  logic        running_valid_i,
  output int          errors_o,
  output int          pending_o,
  output int          answers_o,
  output int          waits_o
);

  typedef struct packed {
    rrts_pkg::status_e status;
    logic [3:0]        thread;
    logic              running;
  } answer_t;

  localparam logic [31:0] NO_CUR = 32'hFFFF_FFFF;

  rrts_pkg::slot_st_e thr_st [SLOT_COUNT];
  logic [31:0] thr_wake [SLOT_COUNT];
  logic        thr_done [SLOT_COUNT];
  logic [3:0]  released [SLOT_COUNT];
  int unsigned rel_top, hi_water;
  logic [31:0] cur, clock_s;
  logic        active, waiting;
  answer_t     answer_q [$];

  function automatic logic cur_ok();
    return cur < hi_water && cur < SLOT_COUNT;
  endfunction

  function automatic void wake_due();
    for (int unsigned i = 0; i < hi_water; i++)
      if (thr_st[i] == rrts_pkg::SLOT_SLEEPING && thr_wake[i] <= clock_s)
        thr_st[i] = rrts_pkg::SLOT_READY;
  endfunction

  function automatic logic any_asleep();
    for (int unsigned i = 0; i < hi_water; i++)
      if (thr_st[i] == rrts_pkg::SLOT_SLEEPING) return 1'b1;
    return 1'b0;
  endfunction

  function automatic rrts_pkg::status_e pick_next();
    int unsigned idx;
    for (int unsigned i = 0; i < hi_water; i++) begin
      idx = (cur + 1 + i) % hi_water;
      if (thr_st[idx] == rrts_pkg::SLOT_READY ||
          (thr_st[idx] == rrts_pkg::SLOT_RUNNING && idx != cur)) begin
        if (thr_st[cur] == rrts_pkg::SLOT_RUNNING) thr_st[cur] = rrts_pkg::SLOT_READY;
        cur = idx;
        thr_st[idx] = rrts_pkg::SLOT_RUNNING;
        waiting = 1'b0;
        return rrts_pkg::ST_OK;
      end
    end
    if (any_asleep()) begin
      waiting = 1'b1;
      return rrts_pkg::ST_WAIT_SLEEP;
    end
    waiting = 1'b0;
    if (thr_st[cur] == rrts_pkg::SLOT_RUNNING) return rrts_pkg::ST_OK;
    if (thr_st[cur] == rrts_pkg::SLOT_FINISHED) begin
      cur = NO_CUR;
      active = 1'b0;
    end
    return rrts_pkg::ST_NO_RUN;
  endfunction

  function automatic answer_t schedule(rrts_pkg::op_e op, logic [15:0] secs,
                                       logic [3:0] tgt);
    answer_t a;
    rrts_pkg::status_e st;
    logic [3:0] made;
    st = rrts_pkg::ST_OK;
    made = '0;
    case (op)
      rrts_pkg::OP_CREATE: begin
        if (rel_top > 0) begin
          rel_top--;
          made = released[rel_top];
        end else if (hi_water >= SLOT_COUNT) begin
          st = rrts_pkg::ST_NO_SLOT;
        end else begin
          made = 4'(hi_water);
          hi_water++;
        end
        if (st == rrts_pkg::ST_OK) begin
          thr_st[made] = rrts_pkg::SLOT_READY;
          thr_done[made] = 1'b0;
          thr_wake[made] = '0;
        end
      end
      rrts_pkg::OP_START: begin
        if (!(active && cur_ok())) begin
          waiting = 1'b0;
          st = rrts_pkg::ST_NO_RUN;
          active = 1'b0;
          cur = NO_CUR;
          for (int unsigned i = 0; i < hi_water; i++)
            if (st == rrts_pkg::ST_NO_RUN && thr_st[i] == rrts_pkg::SLOT_READY) begin
              cur = i;
              thr_st[i] = rrts_pkg::SLOT_RUNNING;
              active = 1'b1;
              st = rrts_pkg::ST_OK;
            end
        end
      end
      rrts_pkg::OP_YIELD, rrts_pkg::OP_SLEEP, rrts_pkg::OP_FINISH: begin
        if (!active || !cur_ok()) st = rrts_pkg::ST_NO_RUN;
        else if (op == rrts_pkg::OP_YIELD) begin
          wake_due();
          st = pick_next();
        end else if (thr_st[cur] != rrts_pkg::SLOT_RUNNING) begin
          st = waiting ? rrts_pkg::ST_WAIT_SLEEP : rrts_pkg::ST_NO_RUN;
        end else begin
          if (op == rrts_pkg::OP_SLEEP) begin
            thr_st[cur] = rrts_pkg::SLOT_SLEEPING;
            thr_wake[cur] = clock_s + 32'(secs);
          end else thr_st[cur] = rrts_pkg::SLOT_FINISHED;
          wake_due();
          st = pick_next();
        end
      end
      rrts_pkg::OP_JOIN: begin
        if (tgt >= hi_water) st = rrts_pkg::ST_BAD_ID;
        else if (thr_done[tgt]) st = rrts_pkg::ST_JOINED;
        else if (thr_st[tgt] != rrts_pkg::SLOT_FINISHED) st = rrts_pkg::ST_NOT_DONE;
        else begin
          thr_done[tgt] = 1'b1;
          if (rel_top < SLOT_COUNT) begin
            released[rel_top] = tgt;
            rel_top++;
          end
        end
      end
      rrts_pkg::OP_TICK: begin
        clock_s++;
        if (waiting && active && cur_ok()) begin
          st = rrts_pkg::ST_WAIT_SLEEP;
          // only the lowest due sleeper wakes here
          for (int unsigned i = 0; i < hi_water; i++)
            if (st == rrts_pkg::ST_WAIT_SLEEP && thr_st[i] == rrts_pkg::SLOT_SLEEPING &&
                thr_wake[i] <= clock_s) begin
              thr_st[i] = rrts_pkg::SLOT_READY;
              st = pick_next();
              break;
            end
        end
      end
      default: ;
    endcase
    a.status = st;
    if (op == rrts_pkg::OP_CREATE) a.thread = (st == rrts_pkg::ST_OK) ? made : 4'd0;
    else a.thread = cur_ok() ? cur[3:0] : 4'd0;
    a.running = cur_ok();
    return a;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %0d, want %0d at %0t", what, got, want, $time);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    answer_t a, w;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        thr_st[i] = rrts_pkg::SLOT_UNUSED;
        thr_wake[i] = '0;
        thr_done[i] = 1'b0;
        released[i] = '0;
      end
      rel_top = 0;
      hi_water = 0;
      cur = NO_CUR;
      active = 1'b0;
      waiting = 1'b0;
      clock_s = '0;
      answer_q.delete();
      errors_o = 0;
      answers_o = 0;
      waits_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        a = schedule(rrts_pkg::op_e'(op_i), sleep_seconds_i, target_thread_i);
        if (a.status == rrts_pkg::ST_WAIT_SLEEP) waits_o++;
        answer_q.push_back(a);
      end
      if (out_valid_i && out_ready_i) begin
        answers_o++;
        if (answer_q.size() == 0) begin
          report("unexpected result beat", 32'd1, 32'd0);
        end else begin
          w = answer_q.pop_front();
          if (status_i != w.status)
            report("status", 32'(status_i), 32'(w.status));
          if (result_thread_i != w.thread)
            report("result_thread", 32'(result_thread_i), 32'(w.thread));
          if (running_valid_i != w.running)
            report("running_valid", 32'(running_valid_i), 32'(w.running));
        end
      end
    end
    pending_o = answer_q.size();
  end

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// event stimulus for the round-robin thread scheduler
// ----------------------------------------------------------------------------
// A directed opening walks through events and answer codes: no free
// slot, bad id, double join, join of a live thread, a long sleep and the
// reuse of a released id. The random part then plays mostly well-formed
// thread lives (create, start, yield, sleep, tick, finish, join) with a
// share of arbitrary events. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;

  localparam int N_RANDOM  = 1030;
  localparam int IDLE_LIMIT = 2000;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [2:0]  op_i;
  logic [15:0] sleep_seconds_i;
  logic [3:0]  target_thread_i;
  logic        out_valid_o, out_ready_i;
  logic [2:0]  status_o;
  logic [3:0]  result_thread_o;
  logic        running_valid_o;
  int          errors, pending, answers, waits;
  int          idle_cycles, sent;
  logic        calm;  // no idling in the last stretch

  round_robin_thread_scheduler u_top (.*);

  rrts_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .op_i, .sleep_seconds_i,
    .target_thread_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .result_thread_i(result_thread_o), .running_valid_i(running_valid_o),
    .errors_o(errors), .pending_o(pending), .answers_o(answers), .waits_o(waits)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver stalls at random, in bursts
  initial begin
    int stall;
    out_ready_i = 1'b1;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        stall--;
        out_ready_i <= (stall == 0);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(1, 3);
        out_ready_i <= 1'b0;
      end else out_ready_i <= 1'b1;
    end
  end

  // watchdog: cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // one input beat; holds valid until taken, then optionally idles
  task automatic send(rrts_pkg::op_e op, logic [15:0] secs, logic [3:0] tgt);
    int gap;
    in_valid_i      <= 1'b1;
    op_i            <= op;
    sleep_seconds_i <= secs;
    target_thread_i <= tgt;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic random_beat();
    int r;
    r = $urandom_range(0, 99);
    // a lifecycle-weighted mix, with some arbitrary noise
    if (r < 12)      send(rrts_pkg::OP_CREATE, 16'($urandom), 4'($urandom));
    else if (r < 18) send(rrts_pkg::OP_START, 16'($urandom), 4'($urandom));
    else if (r < 34) send(rrts_pkg::OP_YIELD, 16'($urandom), 4'($urandom));
    else if (r < 44) send(rrts_pkg::OP_SLEEP,
                          (r < 42) ? 16'($urandom_range(0, 4)) : 16'($urandom),
                          4'($urandom));
    else if (r < 60) send(rrts_pkg::OP_TICK, 16'($urandom), 4'($urandom));
    else if (r < 72) send(rrts_pkg::OP_FINISH, 16'($urandom), 4'($urandom));
    else if (r < 88) send(rrts_pkg::OP_JOIN, 16'($urandom), 4'($urandom_range(0, 15)));
    else             send(rrts_pkg::op_e'(3'($urandom_range(0, 7))), 16'($urandom),
                          4'($urandom));
  endtask

  initial begin
    int t;
    rst_ni = 1'b0;
    calm = 1'b0;
    sent = 0;
    idle_cycles = 0;
    in_valid_i = 1'b0;
    op_i = rrts_pkg::OP_NOP;
    sleep_seconds_i = '0;
    target_thread_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty scheduler answers, then fill every slot
    send(rrts_pkg::OP_YIELD, 16'h0, 4'h0);
    send(rrts_pkg::OP_START, 16'h0, 4'h0);
    send(rrts_pkg::OP_JOIN, 16'h0, 4'hF);
    for (int i = 0; i < 17; i++) send(rrts_pkg::OP_CREATE, 16'hFFFF, 4'h0);  // last is no free slot
    send(rrts_pkg::OP_START, 16'h0, 4'h0);
    send(rrts_pkg::OP_JOIN, 16'h0, 4'h0);              // not finished
    send(rrts_pkg::OP_SLEEP, 16'hFFFF, 4'h0);          // long sleep
    send(rrts_pkg::OP_FINISH, 16'h0, 4'h0);
    send(rrts_pkg::OP_JOIN, 16'h0, 4'h1);
    send(rrts_pkg::OP_JOIN, 16'h0, 4'h1);              // already joined
    send(rrts_pkg::OP_NOP, 16'hFFFF, 4'hF);
    send(rrts_pkg::OP_CREATE, 16'h0, 4'h0);            // reuses released id
    // random, mostly lifecycles; last stretch without idling
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - 100) calm = 1'b1;
      random_beat();
    end
    in_valid_i <= 1'b0;
    t = 0;
    while (pending > 0 && t < 10000) begin
      @(posedge clk_i);
      t++;
    end
    repeat (40) @(posedge clk_i);
    $display("%0d events sent, %0d answers checked, %0d waited on a sleeper",
             sent, answers, waits);
    if (errors == 0 && pending == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
